[hdl/afd_pkg.sv]
// afd_pkg: widths, codes, configuration and queue-entry types for the
// aspect-fit destination rectangle block. No dependencies.
package afd_pkg;

  localparam int SIZE_BITS = 14;
  localparam int FRAC_BITS = 8;

  localparam int PROD_W = 2 * SIZE_BITS;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int SIDE_W = SIZE_BITS + FRAC_BITS;
  localparam int DIFF_W = NUM_W + 2;

  localparam int EXP_POS_W  = 24;
  localparam int EXP_SIZE_W = 23;
  localparam int DWH_W      = (SIDE_W > EXP_SIZE_W) ? SIDE_W : EXP_SIZE_W;

  localparam int OUT_POS_W  = 32;
  localparam int OUT_SIZE_W = 31;

  localparam int IN_DATA_W  = ((2 * SIZE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * OUT_POS_W + 2 * OUT_SIZE_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int FIFO_DEPTH = 4;

  // fit mode codes; codes above FIT_SOURCE act as FIT_SOURCE
  localparam logic [2:0] FIT_STRETCH = 3'd0;
  localparam logic [2:0] FIT_COVER   = 3'd1;
  localparam logic [2:0] FIT_FILL    = 3'd2;
  localparam logic [2:0] FIT_CONTAIN = 3'd3;
  localparam logic [2:0] FIT_SOURCE  = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_FIT_MODE      = 3'd2,
    REG_USE_EXPLICIT  = 3'd3,
    REG_EXPLICIT_X    = 3'd4,
    REG_EXPLICIT_Y    = 3'd5,
    REG_EXPLICIT_W    = 3'd6,
    REG_EXPLICIT_H    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]        image_width;
    logic [SIZE_BITS-1:0]        image_height;
    logic [2:0]                  fit_mode;
    logic                        use_explicit_rect;
    logic signed [EXP_POS_W-1:0] explicit_x;
    logic signed [EXP_POS_W-1:0] explicit_y;
    logic [EXP_SIZE_W-1:0]       explicit_width;
    logic [EXP_SIZE_W-1:0]       explicit_height;
  } cfg_t;

  // One classified query. scale=0: dx/dy/dw/dh are final.
  // scale=1: num/den go through the divider; num becomes the quotient.
  typedef struct packed {
    logic                        scale;
    logic                        use_width;
    logic [SIZE_BITS-1:0]        vw;
    logic [SIZE_BITS-1:0]        vh;
    logic [SIZE_BITS-1:0]        den;
    logic [NUM_W-1:0]            num;
    logic signed [EXP_POS_W-1:0] dx;
    logic signed [EXP_POS_W-1:0] dy;
    logic [DWH_W-1:0]            dw;
    logic [DWH_W-1:0]            dh;
  } item_t;

endpackage

[hdl/afd_front.sv]
// afd_front: accepts viewport words, forms the two cross products and
// classifies each query into a queue entry. Depends on afd_pkg.
module afd_front import afd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,   // view_width, view_height
  output logic                 push,
  output item_t                push_item,
  input  logic                 q_full
);

  logic                 a_vld;
  logic [SIZE_BITS-1:0] a_vw;
  logic [SIZE_BITS-1:0] a_vh;
  logic [PROD_W-1:0]    a_pw;   // vw * ih
  logic [PROD_W-1:0]    a_ph;   // vh * iw

  logic [SIZE_BITS-1:0] iw;
  logic [SIZE_BITS-1:0] ih;
  logic [SIZE_BITS-1:0] in_vw;
  logic [SIZE_BITS-1:0] in_vh;
  logic                 is_scale;
  logic                 width_larger;
  logic                 use_width;

  // zero image size acts as one
  assign iw = (cfg.image_width  == '0) ? SIZE_BITS'(1) : cfg.image_width;
  assign ih = (cfg.image_height == '0) ? SIZE_BITS'(1) : cfg.image_height;

  assign in_vw = s_tdata[SIZE_BITS-1:0];
  assign in_vh = s_tdata[2*SIZE_BITS-1:SIZE_BITS];

  assign s_tready = !a_vld || !q_full;
  assign push     = a_vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (s_tready) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      a_vw <= in_vw;
      a_vh <= in_vh;
      a_pw <= PROD_W'(in_vw) * PROD_W'(ih);
      a_ph <= PROD_W'(in_vh) * PROD_W'(iw);
    end
  end

  assign is_scale = (cfg.fit_mode == FIT_COVER) || (cfg.fit_mode == FIT_FILL) ||
                    (cfg.fit_mode == FIT_CONTAIN);
  assign width_larger = (a_pw >= a_ph);

  always_comb begin
    if (a_pw == a_ph) begin
      use_width = 1'b1;
    end else if (cfg.fit_mode == FIT_CONTAIN) begin
      use_width = !width_larger;
    end else begin
      use_width = width_larger;
    end
  end

  always_comb begin
    push_item           = '0;
    push_item.vw        = a_vw;
    push_item.vh        = a_vh;
    push_item.den       = SIZE_BITS'(1);
    push_item.use_width = use_width;
    if (cfg.use_explicit_rect) begin
      push_item.dx = cfg.explicit_x;
      push_item.dy = cfg.explicit_y;
      push_item.dw = DWH_W'(cfg.explicit_width);
      push_item.dh = DWH_W'(cfg.explicit_height);
    end else if (cfg.fit_mode == FIT_STRETCH) begin
      push_item.dw = DWH_W'(a_vw) << FRAC_BITS;
      push_item.dh = DWH_W'(a_vh) << FRAC_BITS;
    end else if (is_scale) begin
      push_item.scale = 1'b1;
      push_item.num   = NUM_W'(use_width ? a_pw : a_ph) << FRAC_BITS;
      push_item.den   = use_width ? iw : ih;
    end else begin
      push_item.dx = cfg.explicit_x;
      push_item.dy = cfg.explicit_y;
      push_item.dw = DWH_W'(iw) << FRAC_BITS;
      push_item.dh = DWH_W'(ih) << FRAC_BITS;
    end
  end

endmodule

[hdl/afd_fifo.sv]
// afd_fifo: short queue of classified queries between front and back.
// Depends on afd_pkg.
module afd_fifo import afd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head,
  input  logic  pop
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/afd_back.sv]
// afd_back: one-bit-per-stage pipelined divider for the scaled side, then
// centering, saturation and the output register. Depends on afd_pkg.
module afd_back import afd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  item_t                 head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // rect_x, rect_y, rect_width, rect_height
);

  typedef struct packed {
    item_t                it;
    logic [SIZE_BITS-1:0] rem;
  } div_t;

  localparam logic signed [63:0] POS_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] POS_MIN  = -64'sd2147483648;
  localparam logic [63:0]        SIZE_MAX = 64'd2147483647;

  logic       en;
  logic [NUM_W:0] vld;
  div_t       stg [NUM_W+1];

  logic signed [OUT_POS_W-1:0] out_x;
  logic signed [OUT_POS_W-1:0] out_y;
  logic [OUT_SIZE_W-1:0]       out_w;
  logic [OUT_SIZE_W-1:0]       out_h;

  logic signed [OUT_POS_W-1:0] fin_x;
  logic signed [OUT_POS_W-1:0] fin_y;
  logic [OUT_SIZE_W-1:0]       fin_w;
  logic [OUT_SIZE_W-1:0]       fin_h;

  // restoring division, one quotient bit per stage; quotient shifts in
  // at the bottom of num as the dividend shifts out at the top
  function automatic div_t div_step(div_t s);
    div_t                 r;
    logic [SIZE_BITS:0]   t;
    r      = s;
    t      = {s.rem, s.it.num[NUM_W-1]};
    r.it.num = {s.it.num[NUM_W-2:0], 1'b0};
    if (t >= {1'b0, s.it.den}) begin
      r.rem       = SIZE_BITS'(t - {1'b0, s.it.den});
      r.it.num[0] = 1'b1;
    end else begin
      r.rem = t[SIZE_BITS-1:0];
    end
    return r;
  endfunction

  // floor((view - size) / 2), saturated to 32 bits signed
  function automatic logic signed [OUT_POS_W-1:0] center(logic [NUM_W-1:0] view_fx,
                                                         logic [NUM_W-1:0] size);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] h;
    logic signed [63:0]       v;
    d = $signed(DIFF_W'(view_fx) - DIFF_W'(size));
    h = d >>> 1;
    v = {{(64-DIFF_W){h[DIFF_W-1]}}, h};
    if (v > POS_MAX) begin
      v = POS_MAX;
    end else if (v < POS_MIN) begin
      v = POS_MIN;
    end
    return v[OUT_POS_W-1:0];
  endfunction

  function automatic logic [OUT_SIZE_W-1:0] sat_size(logic [NUM_W-1:0] s);
    logic [63:0] v;
    v = 64'(s);
    if (v > SIZE_MAX) begin
      v = SIZE_MAX;
    end
    return v[OUT_SIZE_W-1:0];
  endfunction

  assign en  = !m_tvalid || m_tready;
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].it  <= head;
      stg[0].rem <= '0;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1] <= div_step(stg[k]);
      end
    end
  end

  // final assembly from the last divider stage
  always_comb begin
    logic [NUM_W-1:0] vw_fx;
    logic [NUM_W-1:0] vh_fx;
    logic [NUM_W-1:0] w_full;
    logic [NUM_W-1:0] h_full;
    item_t            it;
    it    = stg[NUM_W].it;
    vw_fx = NUM_W'(it.vw) << FRAC_BITS;
    vh_fx = NUM_W'(it.vh) << FRAC_BITS;
    if (it.use_width) begin
      w_full = vw_fx;
      h_full = it.num;
    end else begin
      w_full = it.num;
      h_full = vh_fx;
    end
    if (it.scale) begin
      fin_x = center(vw_fx, w_full);
      fin_y = center(vh_fx, h_full);
      fin_w = sat_size(w_full);
      fin_h = sat_size(h_full);
    end else begin
      fin_x = {{(OUT_POS_W-EXP_POS_W){it.dx[EXP_POS_W-1]}}, it.dx};
      fin_y = {{(OUT_POS_W-EXP_POS_W){it.dy[EXP_POS_W-1]}}, it.dy};
      fin_w = OUT_SIZE_W'(it.dw);
      fin_h = OUT_SIZE_W'(it.dh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= fin_x;
      out_y <= fin_y;
      out_w <= fin_w;
      out_h <= fin_h;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-OUT_RAW_W){1'b0}}, out_h, out_w, out_y, out_x};

endmodule

[hdl/aspect_fit_dest_rect.sv]
// aspect_fit_dest_rect: top level; configuration registers and the
// front / queue / back chain. Depends on afd_pkg, afd_front, afd_fifo, afd_back.
//
// For each viewport size word (view_width, view_height in whole pixels) the
// block returns one destination rectangle, in 1/256 pixel, for an image of
// the configured size: the stored rectangle when use_explicit_rect is set,
// else stretch, cover / fill, contain (scaled side by integer division,
// rounded down, result centered) or source size placed at the stored x/y.
// Outputs saturate to 32 bits signed (x, y) and 31 bits unsigned (w, h).
// Throughput is one word per clock with no stalls on the output. A word
// passes, in order, the front register, at which the cross products are
// registered, the four-entry queue, the divider's entry stage, the divider
// pipeline and the output register. The queue lets the input keep taking
// words while m_tready is low, until the queue is full. Configuration is
// to be written by the user only when no word is in flight; the block
// itself does not enforce this. The config channel is always ready.
module aspect_fit_dest_rect import afd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // viewport words
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [13:0] view_width, [27:14] view_height
  // rectangle words
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] rect_x, [63:32] rect_y,
                                           // [94:64] rect_width, [125:95] rect_height
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  head_valid;
  item_t head;
  logic  pop;

  assign cfg_ready = 1'b1;

  // register file; each write keeps the low bits of the data word
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width       <= SIZE_BITS'(1);
      cfg.image_height      <= SIZE_BITS'(1);
      cfg.fit_mode          <= FIT_STRETCH;
      cfg.use_explicit_rect <= 1'b0;
      cfg.explicit_x        <= '0;
      cfg.explicit_y        <= '0;
      cfg.explicit_width    <= '0;
      cfg.explicit_height   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg.image_width       <= cfg_data[SIZE_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height      <= cfg_data[SIZE_BITS-1:0];
        REG_FIT_MODE:     cfg.fit_mode          <= cfg_data[2:0];
        REG_USE_EXPLICIT: cfg.use_explicit_rect <= cfg_data[0];
        REG_EXPLICIT_X:   cfg.explicit_x        <= $signed(cfg_data[EXP_POS_W-1:0]);
        REG_EXPLICIT_Y:   cfg.explicit_y        <= $signed(cfg_data[EXP_POS_W-1:0]);
        REG_EXPLICIT_W:   cfg.explicit_width    <= cfg_data[EXP_SIZE_W-1:0];
        REG_EXPLICIT_H:   cfg.explicit_height   <= cfg_data[EXP_SIZE_W-1:0];
        default:          cfg.fit_mode          <= cfg.fit_mode;
      endcase
    end
  end

  // front: cross products and mode decode
  afd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  afd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // back: divider pipeline, centering, saturation, output register
  afd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
